// ===== rtl/sdip_pkg.sv =====
// shared types, constants and helpers for the strict decimal integer parser
package sdip_pkg;

  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned OUT_BITS   = 64;
  localparam int unsigned ACC_BITS   = VALUE_BITS + 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_TRAIL  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef enum logic {
    CFG_SIGNED_MODE  = 1'b0,
    CFG_TARGET_WIDTH = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       is_end;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [OUT_BITS-1:0] value;
  } out_item_t;

  typedef struct packed {
    logic       signed_mode;
    logic [1:0] target_width;
  } cfg_t;

  // parse state seen by the finishing logic and the checks
  typedef struct packed {
    phase_e  phase;
    logic    negative;
    status_e err;
  } parse_st_t;

  // all-ones mask of the configured result width, clipped to the accumulator
  function automatic logic [VALUE_BITS-1:0] width_mask(input logic [1:0] tw);
    int unsigned bits;
    logic [VALUE_BITS-1:0] m;
    bits = 32'd8 << tw;
    if (bits > VALUE_BITS) begin
      bits = VALUE_BITS;
    end
    for (int unsigned i = 0; i < VALUE_BITS; i++) begin
      m[i] = (i < bits);
    end
    return m;
  endfunction

endpackage

// ===== rtl/sdip_finish.sv =====
// end-of-string checks: latched error, signed limit, trailing garbage, target range
module sdip_finish (
  input  sdip_pkg::parse_st_t                   st_i,
  input  logic [sdip_pkg::VALUE_BITS-1:0]       mag_i,
  input  sdip_pkg::cfg_t                        cfg_i,
  output sdip_pkg::out_item_t                   res_o
);

  localparam logic [sdip_pkg::VALUE_BITS-1:0] HalfMax = {1'b0, {(sdip_pkg::VALUE_BITS-1){1'b1}}};

  logic                              neg;
  logic [sdip_pkg::VALUE_BITS-1:0]   sign_lim;
  logic [sdip_pkg::VALUE_BITS-1:0]   wmask;
  logic [sdip_pkg::VALUE_BITS-1:0]   width_lim;
  logic [sdip_pkg::OUT_BITS-1:0]     mag_ext;
  sdip_pkg::status_e                 status;

  assign neg      = cfg_i.signed_mode & st_i.negative;
  assign sign_lim = HalfMax + sdip_pkg::VALUE_BITS'(neg);
  assign wmask    = sdip_pkg::width_mask(cfg_i.target_width);
  // signed range is half the mask, plus one on the negative side
  assign width_lim = cfg_i.signed_mode ? ((wmask >> 1) + sdip_pkg::VALUE_BITS'(neg)) : wmask;
  assign mag_ext  = sdip_pkg::OUT_BITS'(mag_i);

  always_comb begin
    if (st_i.err != sdip_pkg::ST_OK) begin
      status = st_i.err;
    end else if (st_i.phase == sdip_pkg::PH_SPACE || st_i.phase == sdip_pkg::PH_SIGN) begin
      status = sdip_pkg::ST_INVALID;
    end else if (cfg_i.signed_mode && (mag_i > sign_lim)) begin
      status = sdip_pkg::ST_OVERFLOW;
    end else if (st_i.phase != sdip_pkg::PH_DIGITS) begin
      status = sdip_pkg::ST_INVALID;
    end else if (mag_i > width_lim) begin
      status = sdip_pkg::ST_OVERFLOW;
    end else begin
      status = sdip_pkg::ST_OK;
    end
  end

  always_comb begin
    res_o.status = status;
    if (status != sdip_pkg::ST_OK) begin
      res_o.value = '0;
    end else if (neg) begin
      res_o.value = '0 - mag_ext;
    end else begin
      res_o.value = mag_ext;
    end
  end

endmodule

// ===== rtl/sdip_core.sv =====
// parse state registers and the one-character update step
module sdip_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  sdip_pkg::in_item_t    item_i,
  input  sdip_pkg::cfg_t        cfg_i,
  output sdip_pkg::out_item_t   res_o,
  output sdip_pkg::parse_st_t   st_o
);

  sdip_pkg::parse_st_t               st_q, st_d;
  logic [sdip_pkg::VALUE_BITS-1:0]   mag_q, mag_d;

  logic                              is_digit;
  logic                              is_space;
  logic [3:0]                        digit;
  logic [sdip_pkg::ACC_BITS-1:0]     mag_ext;
  logic [sdip_pkg::ACC_BITS-1:0]     prod;
  logic                              acc_ovf;

  assign is_digit = (item_i.char_code >= sdip_pkg::CH_ZERO) &&
                    (item_i.char_code <= sdip_pkg::CH_NINE);
  assign is_space = (item_i.char_code == sdip_pkg::CH_SPACE) ||
                    (item_i.char_code == sdip_pkg::CH_TAB) ||
                    (item_i.char_code == sdip_pkg::CH_LF) ||
                    (item_i.char_code == sdip_pkg::CH_CR) ||
                    (item_i.char_code == sdip_pkg::CH_VT) ||
                    (item_i.char_code == sdip_pkg::CH_FF);
  assign digit    = 4'(item_i.char_code - sdip_pkg::CH_ZERO);

  // times ten as (x << 3) + (x << 1), carry bits above the accumulator flag overflow
  assign mag_ext = sdip_pkg::ACC_BITS'(mag_q);
  assign prod    = (mag_ext << 3) + (mag_ext << 1) + sdip_pkg::ACC_BITS'(digit);
  assign acc_ovf = |prod[sdip_pkg::ACC_BITS-1:sdip_pkg::VALUE_BITS];

  sdip_finish u_finish (
    .st_i  (st_q),
    .mag_i (mag_q),
    .cfg_i (cfg_i),
    .res_o (res_o)
  );

  always_comb begin
    st_d  = st_q;
    mag_d = mag_q;
    if (step_i) begin
      if (item_i.is_end) begin
        st_d.phase    = sdip_pkg::PH_SPACE;
        st_d.negative = 1'b0;
        st_d.err      = sdip_pkg::ST_OK;
        mag_d         = '0;
      end else if (st_q.err == sdip_pkg::ST_OK) begin
        unique case (st_q.phase)
          sdip_pkg::PH_SPACE: begin
            if (is_space) begin
              st_d.phase = sdip_pkg::PH_SPACE;
            end else if (item_i.char_code == sdip_pkg::CH_PLUS) begin
              st_d.phase = sdip_pkg::PH_SIGN;
            end else if (item_i.char_code == sdip_pkg::CH_MINUS) begin
              if (cfg_i.signed_mode) begin
                st_d.negative = 1'b1;
                st_d.phase    = sdip_pkg::PH_SIGN;
              end else begin
                st_d.err = sdip_pkg::ST_UNDERFLOW;
              end
            end else if (is_digit) begin
              if (acc_ovf) begin
                st_d.err = sdip_pkg::ST_OVERFLOW;
              end else begin
                mag_d      = prod[sdip_pkg::VALUE_BITS-1:0];
                st_d.phase = sdip_pkg::PH_DIGITS;
              end
            end else begin
              st_d.err = sdip_pkg::ST_INVALID;
            end
          end
          sdip_pkg::PH_SIGN, sdip_pkg::PH_DIGITS: begin
            if (is_digit) begin
              if (acc_ovf) begin
                st_d.err = sdip_pkg::ST_OVERFLOW;
              end else begin
                mag_d      = prod[sdip_pkg::VALUE_BITS-1:0];
                st_d.phase = sdip_pkg::PH_DIGITS;
              end
            end else if (st_q.phase == sdip_pkg::PH_SIGN) begin
              st_d.err = sdip_pkg::ST_INVALID;
            end else begin
              st_d.phase = sdip_pkg::PH_TRAIL;
            end
          end
          default: begin
            st_d = st_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase    <= sdip_pkg::PH_SPACE;
      st_q.negative <= 1'b0;
      st_q.err      <= sdip_pkg::ST_OK;
      mag_q         <= '0;
    end else begin
      st_q  <= st_d;
      mag_q <= mag_d;
    end
  end

  assign st_o = st_q;

endmodule

// ===== rtl/strict_decimal_integer_parser.sv =====
// top level: input register, parse core, result register and configuration registers
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  in       | in_valid_i / in_ready_o   | in_data_i  {is_end, char_code}
//  out      | out_valid_o / out_ready_i | out_data_o {status, value}
//  cfg      | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// one character per cycle unless an end item waits on a full result register; an accepted
// item is held in the input register, and when it steps the parse state and result register
// update, so a result comes out through the input register and then the result register.
// the critical path is the times-ten add and the 64-bit range compares.
// reset returns to the leading white space phase, signed mode and 64-bit width.
// a stalled result only blocks end items; characters keep flowing past it.
module strict_decimal_integer_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sdip_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sdip_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [1:0]           cfg_data_i
);

  sdip_pkg::in_item_t   in_q;
  logic                 in_valid_q, in_valid_d;
  sdip_pkg::out_item_t  out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  sdip_pkg::cfg_t       cfg_q;
  sdip_pkg::out_item_t  res;
  sdip_pkg::parse_st_t  st;
  logic                 out_free;
  logic                 step;
  logic                 in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  // an end item needs room in the result register, any other item goes straight on
  assign step       = in_valid_q && (!in_q.is_end || out_free);
  assign in_ready_o = !in_valid_q || step;
  assign in_fire    = in_valid_i && in_ready_o;

  sdip_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res),
    .st_o   (st)
  );

  always_comb begin
    in_valid_d  = in_fire ? 1'b1 : (step ? 1'b0 : in_valid_q);
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (step && in_q.is_end) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signed_mode  <= 1'b1;
      cfg_q.target_width <= 2'd3;
    end else if (cfg_we_i) begin
      unique case (sdip_pkg::cfg_idx_e'(cfg_idx_i))
        sdip_pkg::CFG_SIGNED_MODE:  cfg_q.signed_mode  <= cfg_data_i[0];
        sdip_pkg::CFG_TARGET_WIDTH: cfg_q.target_width <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an error result never carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != sdip_pkg::ST_OK) |-> out_data_o.value == '0)
    else $error("error result with nonzero value");

  // an end item always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_q.is_end) |=> out_valid_q)
    else $error("end item produced no result");

  // the parse state is back to its start after an end item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_q.is_end) |=> (st.phase == sdip_pkg::PH_SPACE &&
                               st.err == sdip_pkg::ST_OK && !st.negative))
    else $error("parse state not cleared after end item");

  // a held item that is not consumed stays in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_q)))
    else $error("held item lost");

endmodule

// ===== tb/sv/tb_strict_decimal_integer_parser.sv =====
// testbench for the strict decimal integer parser: directed strings, then random strings
module tb_strict_decimal_integer_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAG_MAX  = ALL_ONES >> (64 - sdip_pkg::VALUE_BITS);
  localparam logic [7:0]  NUL_MARK = "~";  // stands for a zero byte in the directed strings
  localparam int          DIR_ROWS = 28;
  localparam int          PHASES   = 8;
  localparam int          PHASE_ITEMS = 130;

  typedef struct packed {
    logic              sm;
    logic [1:0]        tw;
    logic              typed;
    sdip_pkg::status_e st;
    logic [63:0]       val;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  sdip_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  sdip_pkg::out_item_t out_data_o;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic [1:0]          cfg_data_i = '0;

  // predictor state and its copy of the registers
  sdip_pkg::phase_e  p_phase;
  logic [63:0]       p_mag;
  logic              p_neg;
  sdip_pkg::status_e p_err;
  logic              cfg_signed;
  logic [1:0]        cfg_width;

  sdip_pkg::out_item_t parse_results_q[$];
  sdip_pkg::out_item_t oldest_parse;
  logic [7:0]  text_q[$];
  bit          steady = 1'b0;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  string dir_text[DIR_ROWS] = '{
    "", " \t\n\r\v\f", "+", "-", "0", "+-5",
    "9223372036854775807", "-9223372036854775808", "9223372036854775808",
    "18446744073709551616", "99999999999999999999x", "9223372036854775808 x",
    "12x", "x1", "~7", " \v\f-42", "  -007",
    "-5", " -0 junk", "18446744073709551615", "18446744073709551616",
    "255", "256", "-128", "+128", "-32769", "2147483647", "12 "
  };

  dir_row_t dir_rows[DIR_ROWS] = '{
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_INVALID,   64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_INVALID,   64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_INVALID,   64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_INVALID,   64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_OK,        64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_INVALID,   64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_OK,        64'h7FFF_FFFF_FFFF_FFFF},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_OK,        64'h8000_0000_0000_0000},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_OVERFLOW,  64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_OVERFLOW,  64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_OVERFLOW,  64'd0},
    '{1'b1, 2'd3, 1'b0, sdip_pkg::ST_OK,        64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_INVALID,   64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_INVALID,   64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_INVALID,   64'd0},
    '{1'b1, 2'd3, 1'b1, sdip_pkg::ST_OK,        64'hFFFF_FFFF_FFFF_FFD6},
    '{1'b1, 2'd3, 1'b0, sdip_pkg::ST_OK,        64'd0},
    '{1'b0, 2'd3, 1'b1, sdip_pkg::ST_UNDERFLOW, 64'd0},
    '{1'b0, 2'd3, 1'b1, sdip_pkg::ST_UNDERFLOW, 64'd0},
    '{1'b0, 2'd3, 1'b1, sdip_pkg::ST_OK,        64'hFFFF_FFFF_FFFF_FFFF},
    '{1'b0, 2'd3, 1'b1, sdip_pkg::ST_OVERFLOW,  64'd0},
    '{1'b0, 2'd0, 1'b1, sdip_pkg::ST_OK,        64'd255},
    '{1'b0, 2'd0, 1'b1, sdip_pkg::ST_OVERFLOW,  64'd0},
    '{1'b1, 2'd0, 1'b1, sdip_pkg::ST_OK,        64'hFFFF_FFFF_FFFF_FF80},
    '{1'b1, 2'd0, 1'b1, sdip_pkg::ST_OVERFLOW,  64'd0},
    '{1'b1, 2'd1, 1'b0, sdip_pkg::ST_OK,        64'd0},
    '{1'b1, 2'd2, 1'b0, sdip_pkg::ST_OK,        64'd0},
    '{1'b1, 2'd2, 1'b1, sdip_pkg::ST_INVALID,   64'd0}
  };

  strict_decimal_integer_parser u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("tb: timeout with %0d results outstanding", parse_results_q.size());
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic bit is_blank(input logic [7:0] c);
    return c == sdip_pkg::CH_SPACE || c == sdip_pkg::CH_TAB || c == sdip_pkg::CH_LF ||
           c == sdip_pkg::CH_CR || c == sdip_pkg::CH_VT || c == sdip_pkg::CH_FF;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= sdip_pkg::CH_ZERO && c <= sdip_pkg::CH_NINE;
  endfunction

  function automatic logic [7:0] blank_char(input int unsigned k);
    case (k % 6)
      0: return sdip_pkg::CH_SPACE;
      1: return sdip_pkg::CH_TAB;
      2: return sdip_pkg::CH_LF;
      3: return sdip_pkg::CH_CR;
      4: return sdip_pkg::CH_VT;
      default: return sdip_pkg::CH_FF;
    endcase
  endfunction

  function automatic void clear_parse();
    p_phase = sdip_pkg::PH_SPACE;
    p_mag   = '0;
    p_neg   = 1'b0;
    p_err   = sdip_pkg::ST_OK;
  endfunction

  // accumulate one digit, latching overflow when the next value would not fit
  function automatic void add_digit(input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - sdip_pkg::CH_ZERO);
    if (p_mag > (MAG_MAX - d) / 64'd10) begin
      p_err = sdip_pkg::ST_OVERFLOW;
    end else begin
      p_mag   = p_mag * 64'd10 + d;
      p_phase = sdip_pkg::PH_DIGITS;
    end
  endfunction

  function automatic sdip_pkg::out_item_t finish_parse();
    sdip_pkg::out_item_t r;
    int unsigned         bits;
    logic                neg;
    logic [63:0]         lim;
    sdip_pkg::status_e   st;
    neg     = cfg_signed && p_neg;
    r.value = '0;
    st      = sdip_pkg::ST_OK;
    if (p_err != sdip_pkg::ST_OK) begin
      st = p_err;
    end else if (p_phase == sdip_pkg::PH_SPACE || p_phase == sdip_pkg::PH_SIGN) begin
      st = sdip_pkg::ST_INVALID;
    // signed limit is checked ahead of trailing garbage
    end else if (cfg_signed && p_mag > (MAG_MAX >> 1) + 64'(neg)) begin
      st = sdip_pkg::ST_OVERFLOW;
    end else if (p_phase != sdip_pkg::PH_DIGITS) begin
      st = sdip_pkg::ST_INVALID;
    end else begin
      bits = 8 << cfg_width;
      if (bits > sdip_pkg::VALUE_BITS) begin
        bits = sdip_pkg::VALUE_BITS;
      end
      if (cfg_signed) begin
        lim = (ALL_ONES >> (65 - bits)) + 64'(neg);
      end else begin
        lim = ALL_ONES >> (64 - bits);
      end
      if (p_mag > lim) begin
        st = sdip_pkg::ST_OVERFLOW;
      end else begin
        r.value = neg ? -p_mag : p_mag;
      end
    end
    r.status = st;
    return r;
  endfunction

  function automatic void parse_char(input sdip_pkg::in_item_t it);
    logic [7:0] c;
    c = it.char_code;
    if (it.is_end) begin
      parse_results_q.push_back(finish_parse());
      clear_parse();
      return;
    end
    if (p_err != sdip_pkg::ST_OK) begin
      return;
    end
    case (p_phase)
      sdip_pkg::PH_SPACE: begin
        if (is_blank(c)) begin
        end else if (c == sdip_pkg::CH_PLUS) begin
          p_phase = sdip_pkg::PH_SIGN;
        end else if (c == sdip_pkg::CH_MINUS) begin
          if (cfg_signed) begin
            p_neg   = 1'b1;
            p_phase = sdip_pkg::PH_SIGN;
          end else begin
            p_err = sdip_pkg::ST_UNDERFLOW;
          end
        end else if (is_digit(c)) begin
          add_digit(c);
        end else begin
          p_err = sdip_pkg::ST_INVALID;
        end
      end
      sdip_pkg::PH_SIGN: begin
        if (is_digit(c)) begin
          add_digit(c);
        end else begin
          p_err = sdip_pkg::ST_INVALID;
        end
      end
      sdip_pkg::PH_DIGITS: begin
        if (is_digit(c)) begin
          add_digit(c);
        end else begin
          p_phase = sdip_pkg::PH_TRAIL;
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_item(input sdip_pkg::in_item_t it);
    while (!steady && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    parse_char(it);
    items_sent++;
  endtask

  // sends the characters in text_q, then the end item
  task automatic send_text();
    sdip_pkg::in_item_t it;
    foreach (text_q[i]) begin
      it = '{is_end: 1'b0, char_code: text_q[i]};
      send_item(it);
    end
    it = '{is_end: 1'b1, char_code: 8'($urandom_range(255))};
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic sm, input logic [1:0] tw);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sdip_pkg::CFG_SIGNED_MODE;
    cfg_data_i <= {1'($urandom_range(1)), sm};
    @(posedge clk_i);
    cfg_idx_i  <= sdip_pkg::CFG_TARGET_WIDTH;
    cfg_data_i <= tw;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_signed = sm;
    cfg_width  = tw;
  endtask

  function automatic void load_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i] == NUL_MARK ? 8'h00 : s[i]);
    end
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(3))
      0: return blank_char($urandom_range(5));
      1: return sdip_pkg::CH_ZERO + 8'($urandom_range(9));
      2: return $urandom_range(1) ? sdip_pkg::CH_PLUS : sdip_pkg::CH_MINUS;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // magnitudes are small, random, near the 64-bit maximum or cluster around the limits of the current width
  function automatic logic [63:0] pick_magnitude();
    int unsigned bits;
    logic [63:0] half;
    bits = 8 << cfg_width;
    if (bits > sdip_pkg::VALUE_BITS) begin
      bits = sdip_pkg::VALUE_BITS;
    end
    half = 64'd1 << (bits - 1);
    case ($urandom_range(4))
      0: return 64'($urandom_range(999));
      1: return half - 64'd2 + 64'($urandom_range(3));
      2: return (half << 1) - 64'd2 + 64'($urandom_range(2));
      3: return {$urandom, $urandom} >> $urandom_range(63);
      default: return ALL_ONES - 64'($urandom_range(20));
    endcase
  endfunction

  task automatic build_random_text();
    int unsigned kind;
    int unsigned r;
    string       digits;
    kind = $urandom_range(99);
    text_q.delete();
    if (kind < 12) begin
      repeat ($urandom_range(6)) text_q.push_back(noise_char());
      return;
    end
    repeat ($urandom_range(3)) text_q.push_back(blank_char($urandom_range(5)));
    r = $urandom_range(9);
    if (r < 2) begin
      text_q.push_back(sdip_pkg::CH_PLUS);
    end else if (r < 5) begin
      text_q.push_back(sdip_pkg::CH_MINUS);
    end
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(sdip_pkg::CH_ZERO);
    end
    digits = $sformatf("%0d", pick_magnitude());
    for (int i = 0; i < digits.len(); i++) begin
      text_q.push_back(digits[i]);
    end
    // extra digits push big values past the accumulator
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        text_q.push_back(sdip_pkg::CH_ZERO + 8'($urandom_range(9)));
      end
    end
    if (kind < 30) begin
      if ($urandom_range(1) && text_q.size() != 0) begin
        text_q[$urandom_range(text_q.size() - 1)] = noise_char();
      end else begin
        repeat ($urandom_range(1, 3)) text_q.push_back(noise_char());
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parse_results_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d value %h",
                                  out_data_o.status, out_data_o.value));
      end else begin
        oldest_parse = parse_results_q.pop_front();
        if (out_data_o.status !== oldest_parse.status) begin
          report_mismatch($sformatf("status %0d, want %0d",
                                    out_data_o.status, oldest_parse.status));
        end
        if (out_data_o.value !== oldest_parse.value) begin
          report_mismatch($sformatf("value %h, want %h",
                                    out_data_o.value, oldest_parse.value));
        end
        status_seen[oldest_parse.status]++;
      end
    end
    out_ready_i <= steady || ($urandom_range(99) >= 17);
  end

  initial begin
    int unsigned phase_goal;
    cfg_signed = 1'b1;
    cfg_width  = 2'd3;
    clear_parse();
    wait (rst_ni === 1'b1);
    repeat (2) @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].sm != cfg_signed || dir_rows[r].tw != cfg_width) begin
        set_config(dir_rows[r].sm, dir_rows[r].tw);
      end
      load_text(dir_text[r]);
      send_text();
      if (dir_rows[r].typed) begin
        void'(parse_results_q.pop_back());
        parse_results_q.push_back('{status: dir_rows[r].st, value: dir_rows[r].val});
      end
    end

    // every pairing of sign mode and width, one of them without idling
    for (int p = 0; p < PHASES; p++) begin
      set_config(p % 2 == 0, 2'(3 - p / 2));
      steady     = (p == 4);
      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) begin
        build_random_text();
        send_text();
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("tb: %0d items sent, %0d directed strings, %0d register settings",
             items_sent, DIR_ROWS, PHASES);
    $display("tb: results ok %0d, invalid %0d, overflow %0d, underflow %0d",
             status_seen[sdip_pkg::ST_OK], status_seen[sdip_pkg::ST_INVALID],
             status_seen[sdip_pkg::ST_OVERFLOW], status_seen[sdip_pkg::ST_UNDERFLOW]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== strict_decimal_integer_parser.f =====
rtl/sdip_pkg.sv
rtl/sdip_finish.sv
rtl/sdip_core.sv
rtl/strict_decimal_integer_parser.sv
tb/sv/tb_strict_decimal_integer_parser.sv
